>>> hdl/tsab_pkg.sv
package tsab_pkg;

  // Request codes
  localparam logic [2:0] REQ_ADD       = 3'd0;
  localparam logic [2:0] REQ_FLUSH     = 3'd1;
  localparam logic [2:0] REQ_REMOVE    = 3'd2;
  localparam logic [2:0] REQ_GET_IDX   = 3'd3;
  localparam logic [2:0] REQ_GET_OLDER = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] time_tag;
    logic [63:0]        payload_in;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [63:0] out_time_tag;
    logic [63:0]        out_payload;
    logic [4:0]         entry_count;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       rd_en;
    logic       wr_en;
    logic       wr_new;
    logic       cap_found;
    logic       set_st;
    logic [1:0] st;
    logic       head_adv;
    logic       cnt_inc;
    logic       load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       tag_lt;
    logic       tag_eq;
    logic       out_busy;
    logic [2:0] req_type;
    logic [3:0] position;
  } sts_t;

endpackage

>>> hdl/timestamp_sorted_action_buffer.sv
// Time-ordered action buffer: up to DEPTH entries of (signed 64-bit tag,
// 64-bit payload), held in ascending tag order in a ring memory.
// Input channel in_valid_i/in_ready_o carries one request transaction
// (add, flush up to time, remove oldest, get by index, get last older than).
// Output channel out_valid_o/out_ready_i carries exactly one result per
// request, with the entry count after the request.
// One request is worked on at a time. Each stored entry visited takes a
// memory read, then a compare or move, set by the single read port.
// Remove oldest advances the head unless empty; get by index reads one
// entry unless out of range. Flush scans the entries it removes and stops
// at the first newer one; get last older scans the older entries, then
// reads the last of them. Add scans the entries below the new tag, then
// moves each entry above it up one place before writing the new entry.
// The result is registered: the result state loads it into the output register.
// A finished result sits in an output register; the next request is taken
// while it waits, and its own result is held back until the register frees.
// Reset empties the buffer at once (head and count cleared, no sweep);
// stored entries are undefined until written and never read before that.
module timestamp_sorted_action_buffer #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tsab_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tsab_pkg::rsp_t out_rsp_o
);
  import tsab_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] idx, adv, cnt;

  tsab_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .idx_o(idx), .adv_o(adv), .sts_i(sts), .cnt_i(cnt)
  );

  tsab_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i, .rst_ni, .in_req_i,
    .cmd_i(cmd), .idx_i(idx), .adv_i(adv), .sts_o(sts), .cnt_o(cnt),
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

endmodule

>>> hdl/tsab_datapath.sv
module tsab_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsab_pkg::req_t               in_req_i,
  input  tsab_pkg::cmd_t               cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]   idx_i,
  input  logic [$clog2(DEPTH+1)-1:0]   adv_i,
  output tsab_pkg::sts_t               sts_o,
  output logic [$clog2(DEPTH+1)-1:0]   cnt_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tsab_pkg::rsp_t               out_rsp_o
);
  import tsab_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam int AW = $clog2(DEPTH);

  logic signed [63:0] tag_mem [DEPTH];
  logic [63:0]        pay_mem [DEPTH];

  req_t               req_q;
  logic signed [63:0] rd_tag_q;
  logic [63:0]        rd_pay_q;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [1:0]         st_q;
  logic               found_q;
  logic signed [63:0] res_tag_q;
  logic [63:0]        res_pay_q;
  logic               out_valid_q;
  rsp_t               out_q;
  logic [CW:0]        addr_sum, head_sum;
  logic [AW-1:0]      phys;

  // logical position to ring address
  assign addr_sum = (CW+1)'(head_q) + (CW+1)'(idx_i);
  assign phys     = (addr_sum >= (CW+1)'(DEPTH)) ? AW'(addr_sum - (CW+1)'(DEPTH))
                                                  : AW'(addr_sum);
  assign head_sum = (CW+1)'(head_q) + (CW+1)'(adv_i);

  // head and fill count
  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (cmd_i.head_adv) begin
      head_d = (head_sum >= (CW+1)'(DEPTH)) ? AW'(head_sum - (CW+1)'(DEPTH))
                                            : AW'(head_sum);
      cnt_d  = cnt_q - adv_i;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tag_mem[phys] <= cmd_i.wr_new ? req_q.time_tag  : rd_tag_q;
      pay_mem[phys] <= cmd_i.wr_new ? req_q.payload_in : rd_pay_q;
    end
    if (cmd_i.rd_en) begin
      rd_tag_q <= tag_mem[phys];
      rd_pay_q <= pay_mem[phys];
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_req_i;
    if (cmd_i.cap_found) begin
      res_tag_q <= rd_tag_q;
      res_pay_q <= rd_pay_q;
    end
    if (cmd_i.load_out) begin
      out_q.status       <= st_q;
      out_q.found        <= found_q;
      out_q.out_time_tag <= found_q ? res_tag_q : 64'sd0;
      out_q.out_payload  <= found_q ? res_pay_q : 64'd0;
      out_q.entry_count  <= 5'(cnt_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      st_q        <= ST_OK;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (cmd_i.load_req) begin
        st_q    <= ST_OK;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.set_st)    st_q    <= cmd_i.st;
        if (cmd_i.cap_found) found_q <= 1'b1;
      end
      if (cmd_i.load_out)      out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
    end
  end

  assign sts_o.tag_lt   = rd_tag_q < req_q.time_tag;
  assign sts_o.tag_eq   = rd_tag_q == req_q.time_tag;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign sts_o.req_type = req_q.req_type;
  assign sts_o.position = req_q.position;
  assign cnt_o          = cnt_q;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_q;

endmodule

>>> hdl/tsab_ctrl.sv
module tsab_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output tsab_pkg::cmd_t               cmd_o,
  output logic [$clog2(DEPTH+1)-1:0]   idx_o,
  output logic [$clog2(DEPTH+1)-1:0]   adv_o,
  input  tsab_pkg::sts_t               sts_i,
  input  logic [$clog2(DEPTH+1)-1:0]   cnt_i
);
  import tsab_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_CMP, S_END, S_SH_RD, S_SH_WR,
    S_INS, S_RDX, S_FETCH, S_POP, S_RES
  } state_e;

  state_e        state_q;
  logic [CW-1:0] idx_q, at_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      at_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DEC;
        S_DEC: begin
          idx_q <= '0;
          unique case (sts_i.req_type) inside
            REQ_ADD, REQ_FLUSH, REQ_GET_OLDER: state_q <= S_SCAN;
            REQ_REMOVE: begin
              at_q    <= CW'(1);
              state_q <= (cnt_i == '0) ? S_RES : S_POP;
            end
            REQ_GET_IDX: begin
              idx_q   <= CW'(sts_i.position);
              state_q <= ((CW+4)'(sts_i.position) < (CW+4)'(cnt_i)) ? S_RDX : S_RES;
            end
            default: state_q <= S_RES;
          endcase
        end
        S_SCAN: begin
          if (idx_q == cnt_i) begin
            at_q    <= idx_q;
            state_q <= S_END;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          case (sts_i.req_type)
            REQ_ADD: begin
              if (sts_i.tag_eq) state_q <= S_RES;
              else if (sts_i.tag_lt) begin
                idx_q   <= idx_q + CW'(1);
                state_q <= S_SCAN;
              end else begin
                at_q    <= idx_q;
                state_q <= S_END;
              end
            end
            REQ_FLUSH: begin
              if (sts_i.tag_lt || sts_i.tag_eq) begin
                idx_q   <= idx_q + CW'(1);
                state_q <= S_SCAN;
              end else begin
                at_q    <= idx_q;
                state_q <= S_END;
              end
            end
            default: begin
              if (sts_i.tag_lt) begin
                idx_q   <= idx_q + CW'(1);
                state_q <= S_SCAN;
              end else begin
                at_q    <= idx_q;
                state_q <= S_END;
              end
            end
          endcase
        end
        S_END: begin
          case (sts_i.req_type)
            REQ_ADD: begin
              if (cnt_i >= CW'(DEPTH)) state_q <= S_RES;
              else begin
                idx_q   <= cnt_i;
                state_q <= S_SH_RD;
              end
            end
            REQ_FLUSH: state_q <= S_POP;
            default: begin
              if (at_q != '0) begin
                idx_q   <= at_q - CW'(1);
                state_q <= S_RDX;
              end else begin
                state_q <= S_RES;
              end
            end
          endcase
        end
        S_SH_RD: state_q <= (idx_q == at_q) ? S_INS : S_SH_WR;
        S_SH_WR: begin
          idx_q   <= idx_q - CW'(1);
          state_q <= S_SH_RD;
        end
        S_INS:   state_q <= S_RES;
        S_RDX:   state_q <= S_FETCH;
        S_FETCH: state_q <= S_RES;
        S_POP:   state_q <= S_RES;
        S_RES:   if (!sts_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    idx_o      = idx_q;
    unique case (state_q)
      S_IDLE:  cmd_o.load_req = in_valid_i;
      S_DEC: begin
        if (sts_i.req_type == REQ_REMOVE && cnt_i == '0) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NONE;
        end
        if (sts_i.req_type == REQ_GET_IDX &&
            !((CW+4)'(sts_i.position) < (CW+4)'(cnt_i))) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NONE;
        end
      end
      S_SCAN:  cmd_o.rd_en = (idx_q != cnt_i);
      S_CMP: begin
        if (sts_i.req_type == REQ_ADD && sts_i.tag_eq) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_DUP;
        end
      end
      S_END: begin
        if (sts_i.req_type == REQ_ADD && cnt_i >= CW'(DEPTH)) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_FULL;
        end
        if (sts_i.req_type == REQ_GET_OLDER && at_q == '0) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NONE;
        end
      end
      S_SH_RD: begin
        idx_o       = idx_q - CW'(1);
        cmd_o.rd_en = (idx_q != at_q);
      end
      S_SH_WR: cmd_o.wr_en = 1'b1;
      S_INS: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_RDX:   cmd_o.rd_en     = 1'b1;
      S_FETCH: cmd_o.cap_found = 1'b1;
      S_POP:   cmd_o.head_adv  = 1'b1;
      S_RES:   cmd_o.load_out  = ~sts_i.out_busy;
      default: ;
    endcase
  end

  assign adv_o      = at_q;
  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> hdl/tsab_checker.sv
module tsab_assertions (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input tsab_pkg::rsp_t out_rsp_o
);
  import tsab_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // a returned entry always comes with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> out_rsp_o.status == ST_OK)
    else $error("found with non-ok status");

  // no entry means zero fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |->
      out_rsp_o.out_time_tag == 64'sd0 && out_rsp_o.out_payload == 64'd0)
    else $error("fields not zero without entry");

  // a request accepted leaves no room for another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("two requests back to back");

endmodule

bind timestamp_sorted_action_buffer tsab_assertions u_tsab_assertions (.*);

>>> dv/tsab_checker.sv
module tsab_checker #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  tsab_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  tsab_pkg::rsp_t out_rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  import tsab_pkg::*;

  // Shadow copy of the ordered store
  logic signed [63:0] shadow_tag[DEPTH];
  logic [63:0]        shadow_pay[DEPTH];
  int                 shadow_fill;
  rsp_t               expected_rsp[$];

  assign pending_o = expected_rsp.size();

  // Drop the n oldest entries from the shadow store
  function automatic void shadow_drop(int n);
    if (n > shadow_fill) n = shadow_fill;
    for (int k = n; k < shadow_fill; k++) begin
      shadow_tag[k - n] = shadow_tag[k];
      shadow_pay[k - n] = shadow_pay[k];
    end
    shadow_fill -= n;
  endfunction

  // Apply one request to the shadow store and work out its result
  function automatic rsp_t apply_request(req_t rq);
    rsp_t r;
    int   at;
    bit   dup;
    r = '0;
    r.status = ST_OK;
    case (rq.req_type)
      REQ_ADD: begin
        dup = 0;
        for (int k = 0; k < shadow_fill; k++)
          if (shadow_tag[k] == rq.time_tag) dup = 1;
        if (dup) begin
          r.status = ST_DUP;
        end else if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = shadow_fill;
          for (int k = 0; k < shadow_fill; k++)
            if (shadow_tag[k] > rq.time_tag) begin
              at = k;
              break;
            end
          for (int k = shadow_fill; k > at; k--) begin
            shadow_tag[k] = shadow_tag[k - 1];
            shadow_pay[k] = shadow_pay[k - 1];
          end
          shadow_tag[at] = rq.time_tag;
          shadow_pay[at] = rq.payload_in;
          shadow_fill++;
        end
      end
      REQ_FLUSH: begin
        at = 0;
        while (at < shadow_fill && shadow_tag[at] <= rq.time_tag) at++;
        shadow_drop(at);
      end
      REQ_REMOVE: begin
        if (shadow_fill == 0) r.status = ST_NONE;
        else shadow_drop(1);
      end
      REQ_GET_IDX: begin
        if (int'(rq.position) < shadow_fill) begin
          r.found        = 1'b1;
          r.out_time_tag = shadow_tag[rq.position];
          r.out_payload  = shadow_pay[rq.position];
        end else begin
          r.status = ST_NONE;
        end
      end
      REQ_GET_OLDER: begin
        at = 0;
        while (at < shadow_fill && shadow_tag[at] < rq.time_tag) at++;
        if (at > 0) begin
          r.found        = 1'b1;
          r.out_time_tag = shadow_tag[at - 1];
          r.out_payload  = shadow_pay[at - 1];
        end else begin
          r.status = ST_NONE;
        end
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_fill);
    return r;
  endfunction

  // Predict on each request transaction, compare on each result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      shadow_fill  = 0;
      fail_count_o <= 0;
      expected_rsp.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_rsp.push_back(apply_request(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %p", out_rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.status !== out_rsp_i.status || want.found !== out_rsp_i.found ||
              want.out_time_tag !== out_rsp_i.out_time_tag ||
              want.out_payload !== out_rsp_i.out_payload ||
              want.entry_count !== out_rsp_i.entry_count) begin
            if (fail_count_o < 10)
              $display("ERROR: result mismatch, expected %p got %p", want, out_rsp_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  import tsab_pkg::*;

  localparam int DEPTH     = 16;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1880;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm_phase;
  bit   hold_off;
  logic signed [63:0] tag_pool[8];

  timestamp_sorted_action_buffer #(.DEPTH(DEPTH)) dut (.*);

  tsab_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random 64-bit value, biased to extremes and a small clustered tag set
  function automatic logic [63:0] pick_tag();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom(), $urandom()};
      3: return 64'(signed'($urandom_range(0, 40)) - 20);
      default: return tag_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // Offer one request transaction and wait for its acceptance;
  // valid is dropped by the next idle cycle or by wait_drained
  task automatic send_request(logic [2:0] kind, logic [63:0] tag, logic [63:0] pay,
                              logic [3:0] pos);
    while (!calm_phase && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{req_type: kind, time_tag: tag, payload_in: pay, position: pos};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, a calm stretch, and a long hold-off when asked
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= calm_phase || ($urandom_range(0, 99) >= 19);
    end
  end

  // Watchdog on accepted transactions
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int k;
    logic [2:0] kind;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    calm_phase = 1'b0;
    hold_off   = 1'b0;
    for (k = 0; k < 8; k++) tag_pool[k] = {$urandom(), $urandom()};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty buffer cases, extremes, duplicate, full, flush
    send_request(REQ_REMOVE, '0, '0, '0);
    send_request(REQ_GET_IDX, '0, '0, 4'd0);
    send_request(REQ_GET_OLDER, 64'h7fff_ffff_ffff_ffff, '0, '0);
    send_request(REQ_FLUSH, '0, '0, '0);
    send_request(REQ_ADD, 64'h8000_0000_0000_0000, '1, '0);
    send_request(REQ_ADD, 64'h7fff_ffff_ffff_ffff, '0, '0);
    send_request(REQ_ADD, 64'h7fff_ffff_ffff_ffff, 64'h1234, '0);
    for (k = 0; k < 15; k++)
      send_request(REQ_ADD, 64'(k * 3 - 20), {$urandom(), $urandom()}, '0);
    send_request(REQ_GET_IDX, '0, '0, 4'd15);
    send_request(REQ_GET_OLDER, 64'h8000_0000_0000_0000, '0, '0);
    send_request(3'd7, '1, '1, '1);
    send_request(REQ_FLUSH, 64'h7fff_ffff_ffff_ffff, '0, '0);

    // Pause until drained, then a long receiver hold-off while the sender fills
    wait_drained();
    hold_off = 1'b1;
    for (k = 0; k < 30; k++)
      send_request(REQ_ADD, pick_tag(), {$urandom(), $urandom()}, '0);
    wait_drained();

    // Random mix, with a calm stretch in the middle
    for (k = 0; k < N_RANDOM; k++) begin
      calm_phase = (k >= 600 && k < 900);
      if (k % 250 == 0) for (int j = 0; j < 8; j++) tag_pool[j] = pick_tag();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: kind = REQ_ADD;
        7, 8:                kind = REQ_FLUSH;
        9, 10, 11:           kind = REQ_REMOVE;
        12, 13, 14, 15:      kind = REQ_GET_IDX;
        16, 17, 18:          kind = REQ_GET_OLDER;
        default:             kind = 3'($urandom_range(5, 7));
      endcase
      send_request(kind, pick_tag(), {$urandom(), $urandom()}, 4'($urandom_range(0, 15)));
    end
    calm_phase = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> timestamp_sorted_action_buffer.f
hdl/tsab_pkg.sv
hdl/tsab_datapath.sv
hdl/tsab_ctrl.sv
hdl/timestamp_sorted_action_buffer.sv
hdl/tsab_checker.sv
dv/tsab_checker.sv
dv/tb_top.sv
